>>> design/kle_pkg.sv
package kle_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);

    localparam logic [7:0] KEY_BACKSPACE = 8'd45;
    localparam logic [7:0] KEY_LEFT      = 8'd60;
    localparam logic [7:0] KEY_RIGHT     = 8'd62;

    // what one stack of the cell row does in a cycle
    typedef enum logic [1:0] {
        ST_HOLD = 2'd0,
        ST_PUSH = 2'd1,
        ST_POP  = 2'd2
    } t_stack_op;

    // shift control shared by every cell of the row
    typedef struct packed {
        t_stack_op left_op;
        t_stack_op right_op;
    } t_shift_ctl;

endpackage

>>> design/kle_cell.sv
module kle_cell (
    input  logic              i_clk,
    input  kle_pkg::t_shift_ctl i_ctl,
    input  logic [7:0]        i_left_prev,
    input  logic [7:0]        i_left_next,
    input  logic [7:0]        i_right_prev,
    input  logic [7:0]        i_right_next,
    output logic [7:0]        o_left,
    output logic [7:0]        o_right
);
    import kle_pkg::*;

    logic [7:0] r_left;
    logic [7:0] r_right;
    logic [7:0] n_left;
    logic [7:0] n_right;

    // push takes from the neighbour nearer the cursor, pop from the one further away
    always_comb begin
        unique case (i_ctl.left_op)
            ST_PUSH: n_left = i_left_prev;
            ST_POP:  n_left = i_left_next;
            default: n_left = r_left;
        endcase
        unique case (i_ctl.right_op)
            ST_PUSH: n_right = i_right_prev;
            ST_POP:  n_right = i_right_next;
            default: n_right = r_right;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

>>> design/keystroke_line_editor.sv
// keystroke line editor
//
// input channel (i_s_*): one transfer per key item. i_s_tlast low means a
// keystroke in i_s_tdata: '-' deletes before the cursor, '<' and '>' move the
// cursor, any other byte is inserted. i_s_tlast high ends the line.
// output channel (o_m_*): for each end of line, one transfer per character from
// left to right with o_m_tlast on the final one, or a single transfer with the
// empty flag for an empty line. the overflow flag reports a dropped insert.
//
// a keystroke is applied to the cell row when it is taken, and the next item can
// follow at once. an end of line first walks the cursor back to the start,
// moving each character left of the cursor over to the right stack, then pops
// one character per cycle into the output register while the receiver is not
// stalling. the row of cells is a pair of shift stacks, so the readout is set by
// moving one character a cycle through it.
//
// reset empties the line, clears the overflow flag and drops the output valid.
// a stalled receiver holds the result in the output register; keys are taken
// again as soon as the last result of a line has been loaded.
module keystroke_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] key_code
    input  logic       i_s_tlast,   // operation: end of line
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] char_out
    output logic       o_m_tlast,   // last_char
    output logic [1:0] o_m_tuser    // [0] line_empty, [1] overflow_seen
);
    import kle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REWIND = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_left_cnt, n_left_cnt;
    logic [CNT_W-1:0] r_right_cnt, n_right_cnt;
    logic r_dropped, n_dropped;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_out_last, n_out_last;
    logic       r_out_empty, n_out_empty;
    logic       r_out_ovf, n_out_ovf;

    // cell row: index 0 sits next to the cursor on both stacks
    t_shift_ctl w_ctl;
    logic [7:0] w_left_push;
    logic [7:0] w_right_push;
    logic [7:0] w_left  [LINE_CAPACITY];
    logic [7:0] w_right [LINE_CAPACITY];

    logic w_in_xfer;
    logic w_out_free;
    logic w_full;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = ({1'b0, r_left_cnt} + {1'b0, r_right_cnt})
                        == (CNT_W + 1)'(LINE_CAPACITY);

    genvar g;
    generate
        for (g = 0; g < LINE_CAPACITY; g++) begin : g_cell
            logic [7:0] w_lp, w_ln, w_rp, w_rn;
            if (g == 0) begin : g_first
                assign w_lp = w_left_push;
                assign w_rp = w_right_push;
            end else begin : g_mid
                assign w_lp = w_left[g-1];
                assign w_rp = w_right[g-1];
            end
            if (g == LINE_CAPACITY - 1) begin : g_last
                assign w_ln = '0;
                assign w_rn = '0;
            end else begin : g_inner
                assign w_ln = w_left[g+1];
                assign w_rn = w_right[g+1];
            end
            kle_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_left_prev  (w_lp),
                .i_left_next  (w_ln),
                .i_right_prev (w_rp),
                .i_right_next (w_rn),
                .o_left       (w_left[g]),
                .o_right      (w_right[g])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_left_cnt   = r_left_cnt;
        n_right_cnt  = r_right_cnt;
        n_dropped    = r_dropped;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_ovf    = r_out_ovf;
        w_ctl        = '{left_op: ST_HOLD, right_op: ST_HOLD};
        w_left_push  = i_s_tdata;
        w_right_push = w_left[0];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_s_tlast) begin
                        n_state = S_REWIND;
                    end else begin
                        unique case (i_s_tdata)
                            KEY_BACKSPACE: begin
                                if (r_left_cnt != '0) begin
                                    w_ctl.left_op = ST_POP;
                                    n_left_cnt    = r_left_cnt - 1'b1;
                                end
                            end
                            KEY_LEFT: begin
                                if (r_left_cnt != '0) begin
                                    w_ctl.left_op  = ST_POP;
                                    w_ctl.right_op = ST_PUSH;
                                    n_left_cnt     = r_left_cnt - 1'b1;
                                    n_right_cnt    = r_right_cnt + 1'b1;
                                end
                            end
                            KEY_RIGHT: begin
                                if (r_right_cnt != '0) begin
                                    w_left_push    = w_right[0];
                                    w_ctl.left_op  = ST_PUSH;
                                    w_ctl.right_op = ST_POP;
                                    n_left_cnt     = r_left_cnt + 1'b1;
                                    n_right_cnt    = r_right_cnt - 1'b1;
                                end
                            end
                            default: begin
                                if (w_full) begin
                                    n_dropped = 1'b1;
                                end else begin
                                    w_ctl.left_op = ST_PUSH;
                                    n_left_cnt    = r_left_cnt + 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_REWIND: begin
                // move the cursor to the line start, one character a cycle
                if (r_left_cnt == '0) begin
                    n_state = S_EMIT;
                end else begin
                    w_ctl.left_op  = ST_POP;
                    w_ctl.right_op = ST_PUSH;
                    n_left_cnt     = r_left_cnt - 1'b1;
                    n_right_cnt    = r_right_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_dropped;
                    if (r_right_cnt == '0) begin
                        // empty line: one marked result
                        n_out_char  = '0;
                        n_out_last  = 1'b1;
                        n_out_empty = 1'b1;
                    end else begin
                        n_out_char     = w_right[0];
                        n_out_last     = (r_right_cnt == CNT_W'(1));
                        n_out_empty    = 1'b0;
                        w_ctl.right_op = ST_POP;
                        n_right_cnt    = r_right_cnt - 1'b1;
                    end
                    if (r_right_cnt <= CNT_W'(1)) begin
                        n_right_cnt = '0;
                        n_dropped   = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left_cnt  <= '0;
            r_right_cnt <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left_cnt  <= n_left_cnt;
            r_right_cnt <= n_right_cnt;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // payload of the output register
    always_ff @(posedge i_clk) begin
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_empty};

endmodule

>>> sim/keystroke_line_editor_tb.sv
import kle_pkg::*;

// what one input transfer asks of the editor, carried on tlast
typedef enum logic {
    OP_KEY         = 1'b0,
    OP_END_OF_LINE = 1'b1
} line_op_e;

// one character transfer as it should leave the editor
typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
    logic       line_empty;
    logic       overflow_seen;
} line_char_t;

// gap buffer mirror of the editor plus the queue of characters still owed
class line_checker;
    logic [7:0]  line_text [LINE_CAPACITY];
    int unsigned left_len;
    int unsigned right_len;
    bit          insert_dropped;
    line_char_t  owed_chars [$];
    int unsigned mismatches;
    int unsigned chars_checked;
    int unsigned lines_ended;
    int unsigned lines_dropped;

    function new();
        left_len       = 0;
        right_len      = 0;
        insert_dropped = 1'b0;
        mismatches     = 0;
        chars_checked  = 0;
        lines_ended    = 0;
        lines_dropped  = 0;
    endfunction

    // returns 0 when an edit key had nothing to act on, else 1
    function bit note_transfer(line_op_e op, logic [7:0] key);
        int unsigned total;
        int unsigned n;
        line_char_t  c;
        if (op == OP_KEY) begin
            case (key)
                KEY_BACKSPACE: begin
                    if (left_len == 0) return 1'b0;
                    left_len--;
                end
                KEY_LEFT: begin
                    if (left_len == 0) return 1'b0;
                    line_text[LINE_CAPACITY - right_len - 1] = line_text[left_len - 1];
                    left_len--;
                    right_len++;
                end
                KEY_RIGHT: begin
                    if (right_len == 0) return 1'b0;
                    line_text[left_len] = line_text[LINE_CAPACITY - right_len];
                    left_len++;
                    right_len--;
                end
                default: begin
                    // a full line drops the byte but remembers that it was dropped
                    if (left_len + right_len >= LINE_CAPACITY) begin
                        insert_dropped = 1'b1;
                    end else begin
                        line_text[left_len] = key;
                        left_len++;
                    end
                end
            endcase
            return 1'b1;
        end
        // end of line: left part, then right part, then clear
        total = left_len + right_len;
        c.overflow_seen = insert_dropped;
        c.line_empty    = 1'b0;
        if (total == 0) begin
            c.char_out   = 8'h00;
            c.last_char  = 1'b1;
            c.line_empty = 1'b1;
            owed_chars.push_back(c);
        end else begin
            n = 0;
            for (int unsigned i = 0; i < left_len; i++) begin
                n++;
                c.char_out  = line_text[i];
                c.last_char = (n == total);
                owed_chars.push_back(c);
            end
            for (int unsigned i = LINE_CAPACITY - right_len; i < LINE_CAPACITY; i++) begin
                n++;
                c.char_out  = line_text[i];
                c.last_char = (n == total);
                owed_chars.push_back(c);
            end
        end
        if (insert_dropped) lines_dropped++;
        lines_ended++;
        left_len       = 0;
        right_len      = 0;
        insert_dropped = 1'b0;
        return 1'b1;
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [1:0] user);
        line_char_t got;
        line_char_t exp;
        got.char_out      = data;
        got.last_char     = last;
        got.line_empty    = user[0];
        got.overflow_seen = user[1];
        chars_checked++;
        if (owed_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output transfer: char %02h last %0d empty %0d ovf %0d",
                         got.char_out, got.last_char, got.line_empty, got.overflow_seen);
            return;
        end
        exp = owed_chars.pop_front();
        if (got.char_out != exp.char_out || got.last_char != exp.last_char ||
            got.line_empty != exp.line_empty || got.overflow_seen != exp.overflow_seen) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("wrong output transfer: expected char %02h last %0d empty %0d ovf %0d",
                         exp.char_out, exp.last_char, exp.line_empty, exp.overflow_seen);
                $display("                       got      char %02h last %0d empty %0d ovf %0d",
                         got.char_out, got.last_char, got.line_empty, got.overflow_seen);
            end
        end
    endfunction

    function int pending();
        return owed_chars.size();
    endfunction
endclass

module keystroke_line_editor_tb;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned RANDOM_ITEMS = 330;
    // worst readout: walk back over the whole line, then pop it out
    localparam int unsigned SETTLE_CYCLES = 4 * LINE_CAPACITY;
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;    // [7:0] key_code
    logic       i_s_tlast;    // operation: end of line
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;    // [7:0] char_out
    logic       o_m_tlast;    // last_char
    logic [1:0] o_m_tuser;    // [0] line_empty, [1] overflow_seen

    line_checker sb;
    int unsigned cycle_count = 0;
    int unsigned items_applied = 0;
    bit          sender_steady = 1'b0;

    keystroke_line_editor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // watchdog, well above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input transfer: optional idle gap, then hold tvalid until accepted
    task automatic send_item(line_op_e op, logic [7:0] key);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tlast  <= (op == OP_END_OF_LINE);
        do @(posedge i_clk); while (!o_s_tready);
        void'(sb.note_transfer(op, key));
        items_applied++;
    endtask

    // sender pause: drop tvalid, then wait until nothing is owed any more
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // output side: random stalls, steady stretches and one long hold-off
    task automatic run_receiver();
        int gap;
        int unsigned taken;
        bit hold_done;
        bit steady;
        taken     = 0;
        hold_done = 1'b0;
        steady    = 1'b0;
        forever begin
            if (taken % 24 == 0) steady = ($urandom_range(0, 2) == 0);
            gap = steady ? 0 : $urandom_range(0, 4);
            // long hold-off mid readout so the editor backs up into its input
            if (!hold_done && taken == 40) begin
                gap       = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
            taken++;
        end
    endtask

    initial begin
        int unsigned random_base;
        int unsigned line_no;
        int unsigned n_keys;
        int unsigned r;
        int unsigned failures;
        bit          long_line;
        logic [7:0]  key;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        sb = new();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            run_receiver();
        join_none

        // directed: end of line on an empty line straight after reset
        send_item(OP_END_OF_LINE, 8'h00);
        // edits with nothing to act on are ignored
        send_item(OP_KEY, KEY_BACKSPACE);
        send_item(OP_KEY, KEY_LEFT);
        send_item(OP_KEY, KEY_RIGHT);
        // extreme bytes, and a newline byte sent as a plain keystroke
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, 8'd10);
        send_item(OP_KEY, 8'h41);
        // move in, delete mid line, insert there, run off the right end
        send_item(OP_KEY, KEY_LEFT);
        send_item(OP_KEY, KEY_LEFT);
        send_item(OP_KEY, KEY_BACKSPACE);
        send_item(OP_KEY, 8'h55);
        send_item(OP_KEY, KEY_RIGHT);
        send_item(OP_KEY, KEY_RIGHT);
        send_item(OP_KEY, KEY_RIGHT);
        send_item(OP_KEY, KEY_LEFT);
        // key data on an end of line is don't-care
        send_item(OP_END_OF_LINE, 8'hFF);
        send_item(OP_END_OF_LINE, 8'hAA);
        // one-character line, cursor left at the start
        send_item(OP_KEY, 8'hAA);
        send_item(OP_KEY, KEY_LEFT);
        send_item(OP_KEY, KEY_LEFT);
        send_item(OP_END_OF_LINE, 8'h5A);
        wait_drained();

        // random lines: mostly short edited lines, some long ones that overflow
        random_base = items_applied;
        line_no     = 0;
        while (items_applied - random_base < RANDOM_ITEMS) begin
            line_no++;
            sender_steady = ($urandom_range(0, 3) == 0);
            long_line     = (line_no == 1) || ($urandom_range(0, 9) == 0);
            n_keys        = long_line ? $urandom_range(66, 80) : $urandom_range(0, 12);
            for (int unsigned k = 0; k < n_keys; k++) begin
                r = $urandom_range(0, 99);
                if (long_line) begin
                    if (r < 90)      key = 8'($urandom_range(0, 255));
                    else if (r < 93) key = KEY_BACKSPACE;
                    else if (r < 96) key = KEY_LEFT;
                    else             key = KEY_RIGHT;
                end else begin
                    if (r < 50)      key = 8'($urandom_range(0, 255));
                    else if (r < 65) key = KEY_BACKSPACE;
                    else if (r < 80) key = KEY_LEFT;
                    else if (r < 95) key = KEY_RIGHT;
                    else             key = 8'd10;
                end
                send_item(OP_KEY, key);
            end
            send_item(OP_END_OF_LINE, 8'($urandom_range(0, 255)));
            if (line_no % 8 == 0) wait_drained();
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // let every owed character arrive, then watch for strays
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        failures = sb.mismatches + sb.pending();
        $display("edited %0d lines over %0d input transfers, %0d output transfers",
                 sb.lines_ended, items_applied, sb.chars_checked);
        $display("%0d lines reported a dropped insert, %0d failures", sb.lines_dropped,
                 failures);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
